FILE: rtl/utr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utr_pkg;

  // Fixed sizes of the serial engine.
  localparam int PERIOD_WIDTH  = 16;
  localparam int MAX_DATA_BITS = 8;
  localparam int MIN_DATA_BITS = 5;
  localparam int IDX_W         = 4;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  // Register reset values.
  localparam logic [PERIOD_WIDTH-1:0] BIT_PERIOD_RST    = PERIOD_WIDTH'(16);
  localparam logic [IDX_W-1:0]        DATA_BITS_RST     = IDX_W'(7);
  localparam logic                    PARITY_ENABLE_RST = 1'b0;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_BIT_PERIOD    = 2'd0,
    REG_DATA_BITS     = 2'd1,
    REG_PARITY_ENABLE = 2'd2
  } reg_index_t;

  // Frame phase of either direction.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

  // Effective configuration, already clamped.
  typedef struct packed {
    logic [PERIOD_WIDTH-1:0] period;
    logic [IDX_W-1:0]        bits;
    logic                    parity;
  } cfg_t;

  typedef struct packed {
    logic level;
    logic busy;
  } tx_out_t;

  typedef struct packed {
    logic                     valid;
    logic [MAX_DATA_BITS-1:0] data;
    logic                     parity_bit;
    logic                     error;
  } rx_out_t;

  // Mask that keeps the low data bits of a byte.
  function automatic logic [MAX_DATA_BITS-1:0] data_mask(input logic [IDX_W-1:0] bits);
    logic [MAX_DATA_BITS:0] full;
    full = ((MAX_DATA_BITS+1)'(1) << bits) - (MAX_DATA_BITS+1)'(1);
    return full[MAX_DATA_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/utr_tick_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface utr_tick_if;
  logic       valid;
  logic       ready;
  logic       rx_level;
  logic       send_request;
  logic [7:0] send_byte;

  modport source (output valid, rx_level, send_request, send_byte, input ready);
  modport sink   (input valid, rx_level, send_request, send_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/utr_status_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface utr_status_if;
  logic       valid;
  logic       ready;
  logic       tx_level;
  logic       tx_busy;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_parity_bit;
  logic       parity_error;

  modport source (output valid, tx_level, tx_busy, rx_valid, rx_byte, rx_parity_bit,
                  parity_error, input ready);
  modport sink   (input valid, tx_level, tx_busy, rx_valid, rx_byte, rx_parity_bit,
                  parity_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/utr_tx.sv
`timescale 1ns / 1ps
`default_nettype none

module utr_tx (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              send_request,
  input  wire logic [7:0]        send_byte,
  input  wire utr_pkg::cfg_t     cfg,
  output utr_pkg::tx_out_t       tx_out
);
  import utr_pkg::*;

  phase_t                   phase, phase_next;
  logic [MAX_DATA_BITS:0]   shift, shift_next;
  logic [IDX_W-1:0]         bit_index, bit_index_next;
  logic [PERIOD_WIDTH-1:0]  tick_count, tick_count_next;
  logic [MAX_DATA_BITS-1:0] load_data;
  logic [IDX_W-1:0]         index_m1;

  assign load_data = send_byte & data_mask(cfg.bits);
  assign index_m1  = bit_index_next - IDX_W'(1);

  // Advance the running frame, then start a new one if the line is free.
  always_comb begin
    phase_next      = phase;
    shift_next      = shift;
    bit_index_next  = bit_index;
    tick_count_next = tick_count;
    if (phase != PH_IDLE) begin
      tick_count_next = tick_count + PERIOD_WIDTH'(1);
      if (tick_count_next >= cfg.period) begin
        tick_count_next = '0;
        bit_index_next  = bit_index + IDX_W'(1);
        if (bit_index_next > cfg.bits + IDX_W'(2)) begin
          phase_next     = PH_IDLE;
          bit_index_next = '0;
        end
      end
    end
    if (phase_next == PH_IDLE && send_request) begin
      shift_next      = {cfg.parity & (^load_data), load_data};
      phase_next      = PH_START;
      bit_index_next  = '0;
      tick_count_next = '0;
    end
  end

  // Line level for this tick: start, data, parity slot, then stop.
  always_comb begin
    tx_out.busy  = (phase_next != PH_IDLE);
    tx_out.level = 1'b1;
    if (phase_next != PH_IDLE) begin
      priority if (bit_index_next == '0) begin
        tx_out.level = 1'b0;
      end else if (bit_index_next <= cfg.bits) begin
        tx_out.level = shift_next[index_m1[2:0]];
      end else if (bit_index_next == cfg.bits + IDX_W'(1)) begin
        tx_out.level = shift_next[MAX_DATA_BITS];
      end else begin
        tx_out.level = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      shift      <= '0;
      bit_index  <= '0;
      tick_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      shift      <= shift_next;
      bit_index  <= bit_index_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utr_rx.sv
`timescale 1ns / 1ps
`default_nettype none

module utr_rx (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          rx_level,
  input  wire utr_pkg::cfg_t cfg,
  output utr_pkg::rx_out_t   rx_out
);
  import utr_pkg::*;

  phase_t                   phase, phase_next;
  logic [MAX_DATA_BITS:0]   shift, shift_next;
  logic [IDX_W-1:0]         bit_index, bit_index_next;
  logic [PERIOD_WIDTH-1:0]  tick_count, tick_count_next;
  logic [PERIOD_WIDTH-1:0]  count_dec;
  logic [PERIOD_WIDTH-1:0]  half;
  logic                     prev_level;
  logic                     sample;
  logic                     frame_done;
  logic [MAX_DATA_BITS-1:0] frame_data;

  assign half       = cfg.period >> 1;
  assign count_dec  = (tick_count != '0) ? tick_count - PERIOD_WIDTH'(1) : '0;
  assign sample     = (phase != PH_IDLE) && (count_dec == '0);
  assign frame_done = sample && (phase == PH_DATA) && (bit_index > cfg.bits);
  assign frame_data = shift[MAX_DATA_BITS-1:0] & data_mask(cfg.bits);

  // Next state: hunt for a start edge, then sample at each mid-bit.
  always_comb begin
    phase_next      = phase;
    shift_next      = shift;
    bit_index_next  = bit_index;
    tick_count_next = tick_count;
    if (phase == PH_IDLE) begin
      if (prev_level && !rx_level) begin
        shift_next     = '0;
        bit_index_next = '0;
        if (half == '0) begin
          phase_next      = PH_DATA;
          tick_count_next = cfg.period;
        end else begin
          phase_next      = PH_START;
          tick_count_next = half;
        end
      end
    end else begin
      tick_count_next = count_dec;
      if (sample) begin
        tick_count_next = cfg.period;
        priority if (phase == PH_START) begin
          phase_next     = PH_DATA;
          bit_index_next = '0;
        end else if (bit_index < cfg.bits) begin
          shift_next[bit_index[2:0]] = shift[bit_index[2:0]] | rx_level;
          bit_index_next             = bit_index + IDX_W'(1);
        end else if (bit_index == cfg.bits) begin
          shift_next[MAX_DATA_BITS] = rx_level;
          bit_index_next            = bit_index + IDX_W'(1);
        end else begin
          phase_next      = PH_IDLE;
          bit_index_next  = '0;
          tick_count_next = '0;
        end
      end
    end
  end

  // Report a finished frame; all fields read zero otherwise.
  always_comb begin
    rx_out.valid      = frame_done;
    rx_out.data       = frame_done ? frame_data : '0;
    rx_out.parity_bit = frame_done & shift[MAX_DATA_BITS];
    rx_out.error      = frame_done & cfg.parity & ((^frame_data) ^ shift[MAX_DATA_BITS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      shift      <= '0;
      bit_index  <= '0;
      tick_count <= '0;
      prev_level <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      shift      <= shift_next;
      bit_index  <= bit_index_next;
      tick_count <= tick_count_next;
      prev_level <= rx_level;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uart_transmit_receive.sv
`timescale 1ns / 1ps
`default_nettype none
// An item accepted on the tick channel goes through the input register, then the
// result register. Throughput: one item per cycle unless the status channel stalls;
// each register holds one item, and the serial state advances once per item moved on.
// Reset is synchronous and active high: both lines go idle, registers take their
// defaults (bit_period 16, data_bits 7, parity off) and both channels empty.
module uart_transmit_receive (
  input  wire logic                      clk,
  input  wire logic                      rst,
  utr_tick_if.sink                       tick,
  utr_status_if.source                   status,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [utr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [utr_pkg::DATA_W-1:0] pwdata,
  output logic [utr_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import utr_pkg::*;

  logic [PERIOD_WIDTH-1:0] bit_period;
  logic [IDX_W-1:0]        data_bits;
  logic                    parity_enable;
  cfg_t                    cfg;
  reg_index_t              reg_sel;
  logic                    cfg_write;

  logic       s1_valid;
  logic       s1_rx_level;
  logic       s1_send_request;
  logic [7:0] s1_send_byte;
  logic       out_valid;
  logic       step;
  tx_out_t    tx_out;
  rx_out_t    rx_out;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period    <= BIT_PERIOD_RST;
      data_bits     <= DATA_BITS_RST;
      parity_enable <= PARITY_ENABLE_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_BIT_PERIOD:    bit_period    <= pwdata[PERIOD_WIDTH-1:0];
        REG_DATA_BITS:     data_bits     <= pwdata[IDX_W-1:0];
        REG_PARITY_ENABLE: parity_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BIT_PERIOD:    prdata = DATA_W'(bit_period);
      REG_DATA_BITS:     prdata = DATA_W'(data_bits);
      REG_PARITY_ENABLE: prdata = DATA_W'(parity_enable);
      default:           prdata = '0;
    endcase
  end

  // Effective settings: a zero period acts as one, data bits are clamped.
  always_comb begin
    cfg.period = (bit_period == '0) ? PERIOD_WIDTH'(1) : bit_period;
    priority if (data_bits < IDX_W'(MIN_DATA_BITS)) begin
      cfg.bits = IDX_W'(MIN_DATA_BITS);
    end else if (data_bits > IDX_W'(MAX_DATA_BITS)) begin
      cfg.bits = IDX_W'(MAX_DATA_BITS);
    end else begin
      cfg.bits = data_bits;
    end
    cfg.parity = parity_enable;
  end

  // Two-entry pipeline: the input item moves on whenever the result slot frees.
  assign step       = s1_valid && (!out_valid || status.ready);
  assign tick.ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_rx_level     <= tick.rx_level;
      s1_send_request <= tick.send_request;
      s1_send_byte    <= tick.send_byte;
    end
  end

  utr_tx u_tx (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .send_request (s1_send_request),
    .send_byte    (s1_send_byte),
    .cfg          (cfg),
    .tx_out       (tx_out)
  );

  utr_rx u_rx (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_level (s1_rx_level),
    .cfg      (cfg),
    .rx_out   (rx_out)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status.tx_level      <= tx_out.level;
      status.tx_busy       <= tx_out.busy;
      status.rx_valid      <= rx_out.valid;
      status.rx_byte       <= rx_out.data;
      status.rx_parity_bit <= rx_out.parity_bit;
      status.parity_error  <= rx_out.error;
    end
  end

  assign status.valid = out_valid;

  // An idle transmitter always shows a high line.
  a_idle_line_high: assert property (@(posedge clk) disable iff (rst)
    status.valid && !status.tx_busy |-> status.tx_level)
    else $error("transmit line low while transmitter idle");

  // Without a finished frame the receive fields read zero.
  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    status.valid && !status.rx_valid |->
      status.rx_byte == '0 && !status.rx_parity_bit && !status.parity_error)
    else $error("receive fields set without a finished frame");

  // An empty result slot never stalls the tick channel.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> tick.ready)
    else $error("tick channel stalled with empty result slot");

  // Every item that moves on shows up as a result in the next cycle.
  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("item lost between input and result register");

endmodule

`default_nettype wire
